>>> sv/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
package wsd_pkg;

  // Parser phases, in the order the header fields arrive.
  typedef enum logic [2:0] {
    PH_HDR1  = 3'd0,
    PH_HDR2  = 3'd1,
    PH_EXT16 = 3'd2,
    PH_EXT64 = 3'd3,
    PH_MASK  = 3'd4,
    PH_DATA  = 3'd5
  } phase_t;

  // Seven-bit length codes that announce an extended length field.
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Byte counts of the multi-byte fields, taken modulo eight by the 3-bit counter.
  // The 64-bit length takes eight bytes, so its counter wraps back to zero.
  localparam logic [2:0] EXT16_BYTES = 3'd2;
  localparam logic [2:0] EXT64_BYTES = 3'd0;
  localparam logic [2:0] KEY_BYTES   = 3'd4;

  // One result item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic [3:0] message_opcode;
    logic       end_of_message;
  } result_t;

endpackage

>>> sv/websocket_frame_deframer_core.sv
// WebSocket frame deframer: header parsing, mask key capture and payload unmasking.
//
// Usage: raw received bytes enter on in_valid/in_rx_byte; a transfer happens at a
// rising edge with in_valid high and in_stall low. Each payload byte leaves as one
// result on out_valid with the unmasked byte, out_data_valid set, the opcode of the
// message's first frame and out_end_of_message on the last byte of a fin frame.
// A zero-length fin frame gives one result with out_data_valid low and
// out_end_of_message high. Header bytes give no result.
// A byte taken into the input register is parsed into the output register when the
// parse step runs; its result is shown on the output ports from then on.
// Throughput: one byte per clock while the receiver does not stall. The input register
// and the output register let the parse step run every cycle; its longest path is the
// 64-bit length decrement and the zero test on it.
// When the receiver stalls with a result waiting, the parser holds its byte; in_stall
// follows out_stall in the same cycle while the input register holds a byte, so at
// most one more byte is taken. Nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties both registers and puts the parser back to
// expecting the first header byte of a new message.
module websocket_frame_deframer_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic       out_data_valid,
  output logic [3:0] out_message_opcode,
  output logic       out_end_of_message
);

  // Input register.
  logic       in_full_r, in_full_nxt;
  logic [7:0] byte_r;

  // Parser state.
  wsd_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  logic [63:0]     rem_r, rem_nxt;
  logic [31:0]     key_r, key_nxt;
  logic [1:0]      kidx_r, kidx_nxt;
  logic            masked_r, masked_nxt;
  logic            final_r, final_nxt;
  logic            msg_start_r, msg_start_nxt;
  logic [3:0]      opcode_r, opcode_nxt;

  // Output register.
  logic             out_full_r, out_full_nxt;
  wsd_pkg::result_t res_r, res_nxt;
  logic             res_fire;

  // Shared helper signals of the parse step.
  logic        step;
  logic [6:0]  len7;
  logic [2:0]  cnt_inc;
  logic        len_done;
  logic        key_done;
  logic        masked_eff;
  logic        hdr_done;
  logic [63:0] hdr_len;
  logic [63:0] rem_dec;
  logic        rem_last;
  logic [7:0]  key_byte;

  // The parse step runs whenever a byte waits and the output register can take a result.
  assign step     = in_full_r && (!out_full_r || !out_stall);
  assign in_stall = in_full_r && out_full_r && out_stall;

  assign len7     = byte_r[6:0];
  assign cnt_inc  = cnt_r + 3'd1;
  assign rem_dec  = rem_r - 64'd1;
  assign rem_last = (rem_dec == 64'd0);

  // Length known this step, and the value it ends with.
  always_comb begin
    len_done   = 1'b0;
    key_done   = 1'b0;
    masked_eff = masked_r;
    hdr_len    = rem_r;
    case (phase_r)
      wsd_pkg::PH_HDR2: begin
        masked_eff = byte_r[7];
        hdr_len    = {57'd0, len7};
        len_done   = (len7 != wsd_pkg::LEN_EXT16) && (len7 != wsd_pkg::LEN_EXT64);
      end
      wsd_pkg::PH_EXT16: begin
        hdr_len  = {rem_r[55:0], byte_r};
        len_done = (cnt_inc == wsd_pkg::EXT16_BYTES);
      end
      wsd_pkg::PH_EXT64: begin
        hdr_len  = {rem_r[55:0], byte_r};
        len_done = (cnt_inc == wsd_pkg::EXT64_BYTES);
      end
      wsd_pkg::PH_MASK: begin
        key_done = (cnt_inc == wsd_pkg::KEY_BYTES);
      end
      default: begin
      end
    endcase
  end

  assign hdr_done = (len_done && !masked_eff) || key_done;

  // Key byte for the current payload index; the first key byte received is the top one.
  always_comb begin
    case (kidx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // Next parse phase.
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      wsd_pkg::PH_HDR2, wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64, wsd_pkg::PH_MASK: begin
        if (phase_r == wsd_pkg::PH_HDR2 && len7 == wsd_pkg::LEN_EXT16) begin
          phase_nxt = wsd_pkg::PH_EXT16;
        end else if (phase_r == wsd_pkg::PH_HDR2 && len7 == wsd_pkg::LEN_EXT64) begin
          phase_nxt = wsd_pkg::PH_EXT64;
        end else if (hdr_done) begin
          phase_nxt = (hdr_len != 64'd0) ? wsd_pkg::PH_DATA : wsd_pkg::PH_HDR1;
        end else if (len_done) begin
          phase_nxt = wsd_pkg::PH_MASK;
        end
      end
      wsd_pkg::PH_DATA: begin
        if (rem_last) begin
          phase_nxt = wsd_pkg::PH_HDR1;
        end
      end
      default: begin
        phase_nxt = wsd_pkg::PH_HDR2;
      end
    endcase
  end

  // Field registers and the result of the step.
  always_comb begin
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    key_nxt       = key_r;
    kidx_nxt      = kidx_r;
    masked_nxt    = masked_r;
    final_nxt     = final_r;
    msg_start_nxt = msg_start_r;
    opcode_nxt    = opcode_r;
    res_fire      = 1'b0;
    res_nxt       = '0;
    case (phase_r)
      wsd_pkg::PH_HDR2, wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64, wsd_pkg::PH_MASK: begin
        if (phase_r == wsd_pkg::PH_HDR2) begin
          masked_nxt = byte_r[7];
          cnt_nxt    = 3'd0;
          rem_nxt    = ((len7 == wsd_pkg::LEN_EXT16) || (len7 == wsd_pkg::LEN_EXT64)) ?
                       64'd0 : hdr_len;
        end else if (phase_r == wsd_pkg::PH_MASK) begin
          key_nxt = {key_r[23:0], byte_r};
          cnt_nxt = cnt_inc;
        end else begin
          rem_nxt = hdr_len;
          cnt_nxt = cnt_inc;
        end
        if (len_done) begin
          cnt_nxt = 3'd0;
        end
        // Header complete: an empty fin frame closes the message with an end marker.
        if (hdr_done) begin
          cnt_nxt  = 3'd0;
          kidx_nxt = 2'd0;
          if (hdr_len == 64'd0 && final_r) begin
            msg_start_nxt          = 1'b1;
            res_fire               = 1'b1;
            res_nxt.message_opcode = opcode_r;
            res_nxt.end_of_message = 1'b1;
          end
        end
      end
      wsd_pkg::PH_DATA: begin
        kidx_nxt               = kidx_r + 2'd1;
        rem_nxt                = rem_dec;
        res_fire               = 1'b1;
        res_nxt.data_byte      = masked_r ? (byte_r ^ key_byte) : byte_r;
        res_nxt.data_valid     = 1'b1;
        res_nxt.message_opcode = opcode_r;
        if (rem_last && final_r) begin
          res_nxt.end_of_message = 1'b1;
          msg_start_nxt          = 1'b1;
        end
      end
      default: begin
        // First header byte: fin bit, and the opcode when a new message begins.
        final_nxt = byte_r[7];
        if (msg_start_r) begin
          opcode_nxt    = byte_r[3:0];
          msg_start_nxt = 1'b0;
        end
        cnt_nxt  = 3'd0;
        kidx_nxt = 2'd0;
      end
    endcase
  end

  // Occupancy of the input and output registers.
  always_comb begin
    in_full_nxt = in_full_r;
    if (in_valid && !in_stall) begin
      in_full_nxt = 1'b1;
    end else if (step) begin
      in_full_nxt = 1'b0;
    end
    out_full_nxt = out_full_r;
    if (step && res_fire) begin
      out_full_nxt = 1'b1;
    end else if (out_full_r && !out_stall) begin
      out_full_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r   <= 1'b0;
      out_full_r  <= 1'b0;
      phase_r     <= wsd_pkg::PH_HDR1;
      cnt_r       <= 3'd0;
      rem_r       <= 64'd0;
      key_r       <= 32'd0;
      kidx_r      <= 2'd0;
      masked_r    <= 1'b0;
      final_r     <= 1'b0;
      msg_start_r <= 1'b1;
      opcode_r    <= 4'd0;
    end else begin
      in_full_r  <= in_full_nxt;
      out_full_r <= out_full_nxt;
      if (step) begin
        phase_r     <= phase_nxt;
        cnt_r       <= cnt_nxt;
        rem_r       <= rem_nxt;
        key_r       <= key_nxt;
        kidx_r      <= kidx_nxt;
        masked_r    <= masked_nxt;
        final_r     <= final_nxt;
        msg_start_r <= msg_start_nxt;
        opcode_r    <= opcode_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_rx_byte;
    end
    if (step && res_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_full_r;
  assign out_data_byte      = res_r.data_byte;
  assign out_data_valid     = res_r.data_valid;
  assign out_message_opcode = res_r.message_opcode;
  assign out_end_of_message = res_r.end_of_message;

  // A result without payload is always an end marker with a zero byte.
  a_marker_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_full_r && !res_r.data_valid) |-> (res_r.end_of_message && res_r.data_byte == 8'd0))
    else $error("result without payload is not a clean end marker");

  // The payload phase always has at least one byte still to come.
  a_data_has_length: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == wsd_pkg::PH_DATA) |-> (rem_r != 64'd0))
    else $error("payload phase entered with zero remaining length");

  // A waiting byte blocked by a stalled result stays in the input register.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_full_r && out_full_r && out_stall) |=> (in_full_r && $stable(byte_r)))
    else $error("waiting byte lost while output stalled");

  // Message start is set only in a step that loads an end-of-message result for output.
  a_start_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !msg_start_r && msg_start_nxt) |=> (out_full_r && res_r.end_of_message))
    else $error("message start set without an end-of-message result");

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the WebSocket frame deframer core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Stimulus table row: one raw byte, optionally with a result typed in by hand.
  typedef struct packed {
    logic [7:0]       rx;
    logic             typed;
    logic             has;
    wsd_pkg::result_t want;
  } row_t;

  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned RANDOM_BYTES = 680;
  localparam int unsigned DRAIN_CYCLES = 8;

  // Directed frames: empty fin frame with reserved bits and opcode 15, empty non-fin
  // frame, fin continuation that keeps the first opcode, masked 16-bit length with
  // extreme key bytes, and an empty fin frame announced by a 64-bit length.
  localparam row_t DIRECTED_ROWS [27] = '{
    '{8'hFF, 1'b1, 1'b0, '0},
    '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 4'hF, 1'b1}},
    '{8'h01, 1'b1, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, '0},
    '{8'h80, 1'b1, 1'b0, '0},
    '{8'h01, 1'b1, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 4'h1, 1'b1}},
    '{8'h82, 1'b0, 1'b0, '0},
    '{8'hFE, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h02, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hAA, 1'b0, 1'b0, '0},
    '{8'h55, 1'b0, 1'b0, '0},
    '{8'h55, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h89, 1'b0, 1'b0, '0},
    '{8'h7F, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_data_byte;
  logic       out_data_valid;
  logic [3:0] out_message_opcode;
  logic       out_end_of_message;

  // Parser state of the predictor.
  wsd_pkg::phase_t ph = wsd_pkg::PH_HDR1;
  logic [2:0]      fld_cnt = '0;
  logic [63:0]     frame_left = '0;
  logic [31:0]     key = '0;
  logic [1:0]      key_pos = '0;
  logic            masked_f = 1'b0;
  logic            fin_f = 1'b0;
  logic            msg_start = 1'b1;
  logic [3:0]      msg_opcode = '0;

  wsd_pkg::result_t deframed_q [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned results_seen = 0;
  int unsigned messages_ended = 0;
  int unsigned quiet_cycles = 0;

  websocket_frame_deframer_core DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_data_byte      (out_data_byte),
    .out_data_valid     (out_data_valid),
    .out_message_opcode (out_message_opcode),
    .out_end_of_message (out_end_of_message)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Advance the predicted parser by one received byte.
  task automatic deframe_byte(input logic [7:0] b, output bit made,
                              output wsd_pkg::result_t r);
    logic       len_ready;
    logic       hdr_ready;
    logic [7:0] data;
    made = 1'b0;
    r = '0;
    len_ready = 1'b0;
    hdr_ready = 1'b0;
    case (ph)
      wsd_pkg::PH_HDR2: begin
        masked_f = b[7];
        fld_cnt = '0;
        if (b[6:0] == wsd_pkg::LEN_EXT16) begin
          frame_left = '0;
          ph = wsd_pkg::PH_EXT16;
        end else if (b[6:0] == wsd_pkg::LEN_EXT64) begin
          frame_left = '0;
          ph = wsd_pkg::PH_EXT64;
        end else begin
          frame_left = 64'(b[6:0]);
          len_ready = 1'b1;
        end
      end
      wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
        frame_left = {frame_left[55:0], b};
        fld_cnt = fld_cnt + 3'd1;
        len_ready = (fld_cnt == ((ph == wsd_pkg::PH_EXT16) ? wsd_pkg::EXT16_BYTES :
                                                             wsd_pkg::EXT64_BYTES));
      end
      wsd_pkg::PH_MASK: begin
        key = {key[23:0], b};
        fld_cnt = fld_cnt + 3'd1;
        hdr_ready = (fld_cnt == wsd_pkg::KEY_BYTES);
      end
      wsd_pkg::PH_DATA: begin
        data = b;
        if (masked_f) data = data ^ key[8 * (3 - key_pos) +: 8];
        key_pos = key_pos + 2'd1;
        frame_left = frame_left - 64'd1;
        made = 1'b1;
        r = '{data, 1'b1, msg_opcode, 1'b0};
        if (frame_left == 64'd0) begin
          ph = wsd_pkg::PH_HDR1;
          if (fin_f) begin
            r.end_of_message = 1'b1;
            msg_start = 1'b1;
          end
        end
      end
      default: begin
        fin_f = b[7];
        if (msg_start) begin
          msg_opcode = b[3:0];
          msg_start = 1'b0;
        end
        fld_cnt = '0;
        key_pos = '0;
        ph = wsd_pkg::PH_HDR2;
      end
    endcase
    // Length known: read the key next, or the header is complete.
    if (len_ready) begin
      fld_cnt = '0;
      if (masked_f) ph = wsd_pkg::PH_MASK;
      else hdr_ready = 1'b1;
    end
    // Header complete: start the payload, or close an empty frame.
    if (hdr_ready) begin
      key_pos = '0;
      fld_cnt = '0;
      if (frame_left != 64'd0) begin
        ph = wsd_pkg::PH_DATA;
      end else begin
        ph = wsd_pkg::PH_HDR1;
        if (fin_f) begin
          msg_start = 1'b1;
          made = 1'b1;
          r = '{8'h00, 1'b0, msg_opcode, 1'b1};
        end
      end
    end
  endtask

  // Offer one byte and hold it until the transfer; then record what it should cause.
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input bit has = 1'b0, input wsd_pkg::result_t want = '0);
    bit               made;
    wsd_pkg::result_t r;
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    deframe_byte(b, made, r);
    if (typed) begin
      made = has;
      r = want;
    end
    if (made) deframed_q.push_back(r);
  endtask

  // Send one well-formed frame; len_kind 0 is a 7-bit length, 1 a 16-bit, 2 a 64-bit.
  task automatic send_frame(input logic [7:0] hdr1, input bit masked, input int len_kind,
                            input logic [63:0] len, input int unsigned payload_n);
    int          ext_n;
    logic [31:0] k;
    k = $urandom;
    ext_n = (len_kind == 1) ? 2 : (len_kind == 2) ? 8 : 0;
    send_byte(hdr1);
    if (len_kind == 1) send_byte({masked, wsd_pkg::LEN_EXT16});
    else if (len_kind == 2) send_byte({masked, wsd_pkg::LEN_EXT64});
    else send_byte({masked, len[6:0]});
    for (int i = ext_n - 1; i >= 0; i--) send_byte(len[8 * i +: 8]);
    if (masked) for (int i = 3; i >= 0; i--) send_byte(k[8 * i +: 8]);
    for (int unsigned i = 0; i < payload_n; i++) send_byte(8'($urandom));
    frames_sent++;
  endtask

  // Main sequence: reset, directed table, random frames, then a huge-length frame.
  initial begin
    int unsigned phase_no;
    int unsigned pick;
    int          len_kind;
    logic [63:0] len;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      send_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].has,
                DIRECTED_ROWS[i].want);
    end

    while (bytes_sent < RANDOM_BYTES + $size(DIRECTED_ROWS)) begin
      // Idling phases in quarters: none, sender idle, receiver stall, both.
      phase_no = ((bytes_sent - $size(DIRECTED_ROWS)) * 4) / RANDOM_BYTES;
      send_idle_pct = (phase_no == 1) ? 62 : (phase_no == 3) ? 24 : 0;
      recv_stall_pct = (phase_no == 2) ? 62 : (phase_no == 3) ? 24 : 0;
      // Mostly short frames, some long 7-bit ones and some extended lengths.
      pick = $urandom_range(99, 0);
      if (pick < 70) begin
        len_kind = 0;
        len = 64'($urandom_range(8, 0));
      end else if (pick < 80) begin
        len_kind = 0;
        len = 64'($urandom_range(125, 0));
      end else if (pick < 90) begin
        len_kind = 1;
        len = 64'($urandom_range(300, 0));
      end else begin
        len_kind = 2;
        len = 64'($urandom_range(20, 0));
      end
      send_frame(8'($urandom), 1'($urandom), len_kind, len, int'(len));
    end

    // A length with its top bit set never ends, so this frame closes the stimulus.
    send_frame({1'b1, 3'($urandom), 4'($urandom)}, 1'b1, 2,
               {1'b1, 31'($urandom), 32'($urandom)}, 24);
    in_valid <= 1'b0;

    while (deframed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d bytes in %0d frames sent, %0d results checked, %0d messages ended",
             bytes_sent, frames_sent, results_seen, messages_ended);
    $display("summary: directed table plus random frames over four idling phases");
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Receiver stall pattern, redrawn every cycle.
  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99, 0) < recv_stall_pct);
  end

  task automatic report_field(input string name, input logic [7:0] want, input logic [7:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    errors++;
  endtask

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    wsd_pkg::result_t got;
    wsd_pkg::result_t want;
    got = wsd_pkg::result_t'({out_data_byte, out_data_valid, out_message_opcode,
                              out_end_of_message});
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (got.end_of_message) messages_ended++;
      if (deframed_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        errors++;
      end else begin
        want = deframed_q.pop_front();
        if (got.data_byte !== want.data_byte)
          report_field("data_byte", want.data_byte, got.data_byte);
        if (got.data_valid !== want.data_valid)
          report_field("data_valid", 8'(want.data_valid), 8'(got.data_valid));
        if (got.message_opcode !== want.message_opcode)
          report_field("message_opcode", 8'(want.message_opcode), 8'(got.message_opcode));
        if (got.end_of_message !== want.end_of_message)
          report_field("end_of_message", 8'(want.end_of_message), 8'(got.end_of_message));
      end
    end
  end

  // Watchdog: too long without a transfer on either channel ends the run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
               quiet_cycles, deframed_q.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

endmodule

>>> files.f
sv/wsd_pkg.sv
sv/websocket_frame_deframer_core.sv
bench/testbench.sv
